/* rtl/sbn_pkg.sv */
`default_nettype none

package sbn_pkg;

	// widths of one bound component and of the item fields
	localparam int COMPONENT_BITS = 32;
	localparam int FIELD_BITS     = 32;
	localparam int LIMB_BITS      = 32;
	localparam int STEPS_W        = FIELD_BITS + 1;
	localparam int MED_W          = COMPONENT_BITS + 1;

	// limbs of a component, and of the accumulator that holds cross products
	localparam int LIMBS     = (COMPONENT_BITS + LIMB_BITS - 1) / LIMB_BITS;
	localparam int ACC_LIMBS = (COMPONENT_BITS + 2 * LIMB_BITS + 2 + LIMB_BITS - 1) / LIMB_BITS;
	localparam int ACC_W     = ACC_LIMBS * LIMB_BITS;
	localparam int SH_W      = $clog2(ACC_LIMBS);
	localparam int PROD_W    = 2 * LIMB_BITS;

	// operation codes
	localparam logic [1:0] MODE_ROOT     = 2'd0;
	localparam logic [1:0] MODE_GO       = 2'd1;
	localparam logic [1:0] MODE_APPROACH = 2'd2;
	localparam logic [1:0] MODE_CONTAINS = 2'd3;

	typedef logic [COMPONENT_BITS-1:0] comp_t;
	typedef logic [ACC_W-1:0]          acc_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic                  side;
		logic [FIELD_BITS-1:0] step_count;
		logic [FIELD_BITS-1:0] target_num;
		logic [FIELD_BITS-1:0] target_den;
	} sbn_in_t;

	typedef struct packed {
		logic signed [STEPS_W-1:0] max_steps;
		logic                      inside_res;
		logic [MED_W-1:0]          mediant_num;
		logic [MED_W-1:0]          mediant_den;
		logic                      overflow;
	} sbn_out_t;

	// one command to the multiply-accumulate unit
	typedef struct packed {
		logic                  issue;
		logic                  load;
		logic                  sub;
		logic [SH_W-1:0]       sh;
		logic [LIMB_BITS-1:0]  a;
		logic [FIELD_BITS-1:0] b;
		acc_t                  load_val;
	} mac_cmd_t;

endpackage

`default_nettype wire

/* rtl/sbn_mac.sv */
`default_nettype none

module sbn_mac import sbn_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mac_cmd_t mcmd,
	output acc_t          acc
);

	logic                 vld_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic                 sub_s1;
	logic [SH_W-1:0]      sh_s1;
	acc_t                 addend;
	acc_t                 acc_q;

	assign acc = acc_q;

	// product stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= mcmd.issue;
		end
	end

	// 32x32 product, registered
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mcmd.a) * PROD_W'(mcmd.b);
		sub_s1  <= mcmd.sub;
		sh_s1   <= mcmd.sh;
	end

	// product placed at its limb position
	assign addend = acc_t'(prod_s1) << (sh_s1 * LIMB_BITS);

	// accumulate modulo 2^ACC_W
	always_ff @(posedge clk) begin
		if (mcmd.load) begin
			acc_q <= mcmd.load_val;
		end else if (vld_s1) begin
			acc_q <= sub_s1 ? acc_q - addend : acc_q + addend;
		end
	end

endmodule

`default_nettype wire

/* rtl/stern_brocot_navigator_core.sv */
`default_nettype none

// channel  | ports                    | beat taken when
// ---------+--------------------------+-------------------------------
// command  | start, busy, cmd         | start high while busy is low
// result   | done, res                | done high (one cycle, no stall)
//
// one multiply-accumulate unit (32x32 product, then accumulate) does all products.
// root goes straight to done; go runs a numerator pass and a denominator pass;
// contains runs two cross-product passes and one compare; approach runs the same
// two passes, then one pass of the shared unit per search probe, at most 33 probes.
// reset puts the node at the root (0/1, 1/0); a new beat can be taken while
// done is showing the previous result; results are never held off.

module stern_brocot_navigator_core import sbn_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire sbn_in_t cmd,
	output logic         done,
	output sbn_out_t     res
);

	localparam int CNT_MAX = (2 * LIMBS > ACC_LIMBS) ? 2 * LIMBS : ACC_LIMBS;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int SRCH_W  = FIELD_BITS + 2;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_GO_N      = 4'd1;
	localparam logic [3:0] ST_GO_D      = 4'd2;
	localparam logic [3:0] ST_GO_END    = 4'd3;
	localparam logic [3:0] ST_CALC_A    = 4'd4;
	localparam logic [3:0] ST_CALC_B    = 4'd5;
	localparam logic [3:0] ST_LOAD_B    = 4'd6;
	localparam logic [3:0] ST_CONT      = 4'd7;
	localparam logic [3:0] ST_SRCH_MAC  = 4'd8;
	localparam logic [3:0] ST_SRCH_EVAL = 4'd9;
	localparam logic [3:0] ST_FIN       = 4'd10;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	comp_t                  ln_q, ld_q, rn_q, rd_q;
	logic                   done_q;
	sbn_in_t                in_q;
	acc_t                   a_q, b_q;
	comp_t                  nn_q;
	logic                   novf_q;
	logic [FIELD_BITS:0]    lo_q;
	logic signed [SRCH_W-1:0] hi_q;
	logic [STEPS_W-1:0]     steps_q;
	logic                   ins_q;
	logic                   ovf_q;
	sbn_out_t               res_q;

	mac_cmd_t               mcmd;
	acc_t                   acc;

	logic                   accept;
	logic                   pass_st;
	logic [CNT_W-1:0]       pass_n;
	logic                   pass_end;
	logic [SH_W-1:0]        lidx;
	logic [SH_W-1:0]        lidx2;
	comp_t                  sn, sd, on, od;
	logic [SRCH_W-1:0]      mid_sum;
	logic [FIELD_BITS-1:0]  mid;
	logic                   mid_nz;
	logic                   tinf;
	logic                   l_inf, r_inf, lm_inf, rm_inf;
	logic                   a_neg, b_pos, c_neg, c_pos;
	logic                   lt1, lt2, probe_ok, cont_ok;
	logic signed [SRCH_W-1:0] lo_s, nlo_s, nhi_s, mid_s;
	logic                   again;
	logic [FIELD_BITS:0]    lo_fin;
	logic                   go_ovf;
	logic [FIELD_BITS-1:0]  tmax;

	function automatic logic [LIMB_BITS-1:0] comp_limb(input comp_t v,
			input logic [SH_W-1:0] idx);
		logic [LIMBS*LIMB_BITS-1:0] ext;
		ext = (LIMBS*LIMB_BITS)'(v);
		return ext[idx*LIMB_BITS +: LIMB_BITS];
	endfunction

	function automatic logic [LIMB_BITS-1:0] acc_limb(input acc_t v,
			input logic [SH_W-1:0] idx);
		return v[idx*LIMB_BITS +: LIMB_BITS];
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	// chosen and other bound for go
	assign sn = in_q.side ? rn_q : ln_q;
	assign sd = in_q.side ? rd_q : ld_q;
	assign on = in_q.side ? ln_q : rn_q;
	assign od = in_q.side ? ld_q : rd_q;

	// pass length of the states that drive the shared unit
	always_comb begin
		pass_st = 1'b1;
		pass_n  = '0;
		unique case (state_q)
			ST_GO_N, ST_GO_D:       pass_n = CNT_W'(LIMBS);
			ST_CALC_A, ST_CALC_B:   pass_n = CNT_W'(2 * LIMBS);
			ST_SRCH_MAC:            pass_n = CNT_W'(ACC_LIMBS);
			default:                pass_st = 1'b0;
		endcase
	end

	assign pass_end = (cnt_q == pass_n);
	assign lidx     = cnt_q[SH_W-1:0];
	assign lidx2    = SH_W'(cnt_q - CNT_W'(LIMBS));

	// search midpoint
	assign mid_sum = SRCH_W'(lo_q) + SRCH_W'(hi_q);
	assign mid     = mid_sum[FIELD_BITS:1];
	assign mid_nz  = (mid != '0);

	// unit command
	always_comb begin
		mcmd       = '0;
		mcmd.issue = pass_st && (cnt_q < pass_n);
		mcmd.load  = pass_st && (cnt_q == '0);
		if (pass_st) begin
			unique case (state_q)
				ST_GO_N: begin
					mcmd.load_val = acc_t'(on);
					mcmd.a        = comp_limb(sn, lidx);
					mcmd.b        = in_q.step_count;
					mcmd.sh       = lidx;
				end
				ST_GO_D: begin
					mcmd.load_val = acc_t'(od);
					mcmd.a        = comp_limb(sd, lidx);
					mcmd.b        = in_q.step_count;
					mcmd.sh       = lidx;
				end
				ST_CALC_A, ST_CALC_B: begin
					if (cnt_q < CNT_W'(LIMBS)) begin
						mcmd.a  = comp_limb((state_q == ST_CALC_A) ? ln_q : rn_q, lidx);
						mcmd.b  = in_q.target_den;
						mcmd.sh = lidx;
					end else if (mcmd.issue) begin
						mcmd.a   = comp_limb((state_q == ST_CALC_A) ? ld_q : rd_q, lidx2);
						mcmd.b   = in_q.target_num;
						mcmd.sub = 1'b1;
						mcmd.sh  = lidx2;
					end
				end
				default: begin
					mcmd.load_val = in_q.side ? a_q : b_q;
					if (mcmd.issue) begin
						mcmd.a = acc_limb(in_q.side ? b_q : a_q, lidx);
					end
					mcmd.b  = mid;
					mcmd.sh = lidx;
				end
			endcase
		end
	end

	sbn_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.mcmd   (mcmd),
		.acc    (acc)
	);

	// infinity tests on bounds, fixed and moved
	assign tinf   = (in_q.target_num != '0) && (in_q.target_den == '0);
	assign l_inf  = (ln_q != '0) && (ld_q == '0);
	assign r_inf  = (rn_q != '0) && (rd_q == '0);
	assign lm_inf = ((ln_q != '0) || (mid_nz && (rn_q != '0)))
		&& (ld_q == '0) && (!mid_nz || (rd_q == '0));
	assign rm_inf = ((rn_q != '0) || (mid_nz && (ln_q != '0)))
		&& (rd_q == '0) && (!mid_nz || (ld_q == '0));

	// signs of the cross-product differences
	assign a_neg = a_q[ACC_W-1];
	assign b_pos = !b_q[ACC_W-1] && (b_q != '0);
	assign c_neg = acc[ACC_W-1];
	assign c_pos = !acc[ACC_W-1] && (acc != '0);

	// target strictly between bounds after the probe move
	always_comb begin
		if (in_q.side) begin
			lt1 = !lm_inf && (tinf || c_neg);
			lt2 = !tinf && (r_inf || b_pos);
		end else begin
			lt1 = !l_inf && (tinf || a_neg);
			lt2 = !tinf && (rm_inf || c_pos);
		end
	end

	assign probe_ok = lt1 && lt2;
	assign cont_ok  = !l_inf && (tinf || a_neg) && !tinf && (r_inf || b_pos);

	// binary search step
	assign lo_s   = $signed(SRCH_W'(lo_q));
	assign mid_s  = $signed(SRCH_W'(mid));
	assign nlo_s  = mid_s + SRCH_W'(1);
	assign nhi_s  = mid_s - SRCH_W'(1);
	assign again  = probe_ok ? (nlo_s <= hi_q) : (lo_s <= nhi_s);
	assign lo_fin = probe_ok ? nlo_s[FIELD_BITS:0] : lo_q;

	assign go_ovf = novf_q || (acc[ACC_W-1:COMPONENT_BITS] != '0);
	assign tmax   = (cmd.target_num > cmd.target_den) ? cmd.target_num : cmd.target_den;

	// sequencer and node state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ln_q    <= '0;
			ld_q    <= comp_t'(1);
			rn_q    <= comp_t'(1);
			rd_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			if (pass_st) begin
				cnt_q <= pass_end ? '0 : cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.mode)
							MODE_ROOT: begin
								ln_q    <= '0;
								ld_q    <= comp_t'(1);
								rn_q    <= comp_t'(1);
								rd_q    <= '0;
								state_q <= ST_FIN;
							end
							MODE_GO:  state_q <= ST_GO_N;
							default:  state_q <= ST_CALC_A;
						endcase
					end
				end
				ST_GO_N:     if (pass_end) state_q <= ST_GO_D;
				ST_GO_D:     if (pass_end) state_q <= ST_GO_END;
				ST_GO_END: begin
					if (!go_ovf) begin
						if (in_q.side) begin
							ln_q <= nn_q;
							ld_q <= acc[COMPONENT_BITS-1:0];
						end else begin
							rn_q <= nn_q;
							rd_q <= acc[COMPONENT_BITS-1:0];
						end
					end
					state_q <= ST_FIN;
				end
				ST_CALC_A:   if (pass_end) state_q <= ST_CALC_B;
				ST_CALC_B:   if (pass_end) state_q <= ST_LOAD_B;
				ST_LOAD_B: begin
					state_q <= (in_q.mode == MODE_CONTAINS) ? ST_CONT : ST_SRCH_MAC;
				end
				ST_CONT:     state_q <= ST_FIN;
				ST_SRCH_MAC: if (pass_end) state_q <= ST_SRCH_EVAL;
				ST_SRCH_EVAL: state_q <= again ? ST_SRCH_MAC : ST_FIN;
				ST_FIN:      state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload, partial results and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q    <= cmd;
			steps_q <= '0;
			ins_q   <= 1'b0;
			ovf_q   <= 1'b0;
			lo_q    <= '0;
			hi_q    <= $signed(SRCH_W'(tmax));
		end
		if (state_q == ST_GO_D && cnt_q == '0) begin
			nn_q   <= acc[COMPONENT_BITS-1:0];
			novf_q <= (acc[ACC_W-1:COMPONENT_BITS] != '0);
		end
		if (state_q == ST_GO_END) begin
			ovf_q <= go_ovf;
		end
		if (state_q == ST_CALC_B && cnt_q == '0) begin
			a_q <= acc;
		end
		if (state_q == ST_LOAD_B) begin
			b_q <= acc;
		end
		if (state_q == ST_CONT) begin
			ins_q <= cont_ok;
		end
		if (state_q == ST_SRCH_EVAL) begin
			if (probe_ok) begin
				lo_q <= nlo_s[FIELD_BITS:0];
			end else begin
				hi_q <= nhi_s;
			end
			if (!again) begin
				steps_q <= STEPS_W'(lo_fin) - STEPS_W'(1);
			end
		end
		if (state_q == ST_FIN) begin
			res_q.max_steps   <= $signed(steps_q);
			res_q.inside_res  <= ins_q;
			res_q.mediant_num <= MED_W'(ln_q) + MED_W'(rn_q);
			res_q.mediant_den <= MED_W'(ld_q) + MED_W'(rd_q);
			res_q.overflow    <= ovf_q;
		end
	end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench import sbn_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 2;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 12;

	typedef logic [127:0]              wide_t;
	typedef logic signed [STEPS_W-1:0] steps_t;
	typedef logic [FIELD_BITS-1:0]     field_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	sbn_in_t  cmd;
	logic     done;
	sbn_out_t res;

	// shadow copy of the node bounds
	comp_t lb_num, lb_den, rb_num, rb_den;

	sbn_out_t node_expect_q[$];
	int       fail_count = 0;
	int       items_sent = 0;
	bit       gaps_on    = 1'b1;

	stern_brocot_navigator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// fraction compares, a/0 with a>0 is infinity, 0/0 orders only below infinity
	function automatic bit is_inf(wide_t n, wide_t d);
		return n != '0 && d == '0;
	endfunction

	function automatic bit below_target(wide_t xn, wide_t xd, wide_t tn, wide_t td);
		if (is_inf(xn, xd))
			return 1'b0;
		if (tn != '0 && td == '0)
			return 1'b1;
		return xn * td < xd * tn;
	endfunction

	function automatic bit target_below(wide_t tn, wide_t td, wide_t xn, wide_t xd);
		if (tn != '0 && td == '0)
			return 1'b0;
		if (is_inf(xn, xd))
			return 1'b1;
		return xd * tn < xn * td;
	endfunction

	function automatic bit strictly_inside(wide_t ln, wide_t ld, wide_t rn, wide_t rd,
	                                       wide_t tn, wide_t td);
		return below_target(ln, ld, tn, td) && target_below(tn, td, rn, rd);
	endfunction

	// target test on the node moved k steps along one side
	function automatic bit inside_after_steps(bit side, wide_t k, wide_t tn, wide_t td);
		wide_t ln, ld, rn, rd;
		ln = wide_t'(lb_num);
		ld = wide_t'(lb_den);
		rn = wide_t'(rb_num);
		rd = wide_t'(rb_den);
		if (side) begin
			ln = ln + k * wide_t'(rb_num);
			ld = ld + k * wide_t'(rb_den);
		end else begin
			rn = rn + k * wide_t'(lb_num);
			rd = rd + k * wide_t'(lb_den);
		end
		return strictly_inside(ln, ld, rn, rd, tn, td);
	endfunction

	// binary search for the largest k that keeps the target inside
	function automatic steps_t approach_limit(bit side, wide_t tn, wide_t td);
		longint lo, hi, mid;
		lo = 0;
		hi = (tn > td) ? longint'(tn) : longint'(td);
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (inside_after_steps(side, wide_t'(mid), tn, td))
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return steps_t'(lo - 1);
	endfunction

	// expected result of one command, advances the shadow node
	function automatic sbn_out_t predict_node_step(sbn_in_t c);
		sbn_out_t o;
		wide_t    grow_n, grow_d;
		o = '0;
		case (c.mode)
			MODE_ROOT: begin
				lb_num = 0;
				lb_den = 1;
				rb_num = 1;
				rb_den = 0;
			end
			MODE_GO: begin
				if (c.side) begin
					grow_n = wide_t'(lb_num) + wide_t'(c.step_count) * wide_t'(rb_num);
					grow_d = wide_t'(lb_den) + wide_t'(c.step_count) * wide_t'(rb_den);
				end else begin
					grow_n = wide_t'(rb_num) + wide_t'(c.step_count) * wide_t'(lb_num);
					grow_d = wide_t'(rb_den) + wide_t'(c.step_count) * wide_t'(lb_den);
				end
				if ((grow_n >> COMPONENT_BITS) != 0 || (grow_d >> COMPONENT_BITS) != 0) begin
					o.overflow = 1'b1;
				end else if (c.side) begin
					lb_num = comp_t'(grow_n);
					lb_den = comp_t'(grow_d);
				end else begin
					rb_num = comp_t'(grow_n);
					rb_den = comp_t'(grow_d);
				end
			end
			MODE_APPROACH: begin
				o.max_steps = approach_limit(c.side, wide_t'(c.target_num),
				                             wide_t'(c.target_den));
			end
			default: begin
				o.inside_res = strictly_inside(wide_t'(lb_num), wide_t'(lb_den),
				                               wide_t'(rb_num), wide_t'(rb_den),
				                               wide_t'(c.target_num), wide_t'(c.target_den));
			end
		endcase
		o.mediant_num = {1'b0, lb_num} + {1'b0, rb_num};
		o.mediant_den = {1'b0, lb_den} + {1'b0, rb_den};
		return o;
	endfunction

	function automatic sbn_in_t make_cmd(logic [1:0] m, bit s, field_t k, field_t tn,
	                                     field_t td);
		sbn_in_t c;
		c.mode       = m;
		c.side       = s;
		c.step_count = k;
		c.target_num = tn;
		c.target_den = td;
		return c;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// one command beat, prediction taken at the accepting edge
	task automatic send_beat(input sbn_in_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd   <= item;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		node_expect_q.push_back(predict_node_step(item));
		items_sent++;
	endtask

	// target near or inside the current node, or an odd one
	task automatic pick_target(output field_t tn, output field_t td);
		wide_t a, b, wn, wd;
		case ($urandom_range(0, 6))
			0, 1, 2: begin
				a  = wide_t'($urandom_range(0, 6));
				b  = wide_t'($urandom_range(0, 6));
				wn = a * wide_t'(lb_num) + b * wide_t'(rb_num);
				wd = a * wide_t'(lb_den) + b * wide_t'(rb_den);
				if ($urandom_range(0, 3) == 0 && wn != '0)
					wn = ($urandom_range(0, 1) != 0) ? wn + 1 : wn - 1;
				if ((wn >> FIELD_BITS) != 0 || (wd >> FIELD_BITS) != 0) begin
					wn = wide_t'($urandom);
					wd = wide_t'($urandom);
				end
				tn = field_t'(wn);
				td = field_t'(wd);
			end
			3: begin
				tn = $urandom >> $urandom_range(0, 31);
				td = $urandom >> $urandom_range(0, 31);
			end
			4: begin
				tn = $urandom_range(0, 12);
				td = $urandom_range(0, 12);
			end
			5: begin
				tn = ($urandom_range(0, 1) != 0) ? $urandom : '0;
				td = '0;
			end
			default: begin
				tn = $urandom;
				td = $urandom;
			end
		endcase
	endtask

	// root, extremes of the count, overflow, infinite and empty targets
	task automatic test_directed();
		send_beat(make_cmd(MODE_ROOT, 1'b0, '0, '0, '0));
		send_beat(make_cmd(MODE_CONTAINS, 1'b0, '0, 32'd1, 32'd1));
		send_beat(make_cmd(MODE_CONTAINS, 1'b0, '0, 32'd0, 32'd0));
		send_beat(make_cmd(MODE_CONTAINS, 1'b1, '0, 32'd5, 32'd0));
		send_beat(make_cmd(MODE_CONTAINS, 1'b0, '0, 32'd0, 32'd7));
		send_beat(make_cmd(MODE_APPROACH, 1'b1, '0, 32'd0, 32'd0));
		send_beat(make_cmd(MODE_APPROACH, 1'b1, '0, '1, 32'd1));
		send_beat(make_cmd(MODE_APPROACH, 1'b0, '0, 32'd1, '1));
		send_beat(make_cmd(MODE_APPROACH, 1'b1, '0, 32'd7, 32'd0));
		send_beat(make_cmd(MODE_GO, 1'b1, '0, '1, '1));
		send_beat(make_cmd(MODE_GO, 1'b1, '1, '0, '0));
		send_beat(make_cmd(MODE_GO, 1'b1, 32'd1, '0, '0));
		send_beat(make_cmd(MODE_GO, 1'b0, '1, '0, '0));
		send_beat(make_cmd(MODE_CONTAINS, 1'b1, '0, '1, 32'd0));
		send_beat(make_cmd(MODE_ROOT, 1'b1, '1, '1, '1));
		send_beat(make_cmd(MODE_GO, 1'b0, 32'd3, '0, '0));
		send_beat(make_cmd(MODE_GO, 1'b1, 32'd2, '0, '0));
		send_beat(make_cmd(MODE_CONTAINS, 1'b0, '0, 32'd1, 32'd4));
		send_beat(make_cmd(MODE_APPROACH, 1'b0, '0, 32'd3, 32'd11));
		send_beat(make_cmd(MODE_APPROACH, 1'b1, '0, 32'd3, 32'd11));
		send_beat(make_cmd(MODE_APPROACH, 1'b0, '0, '1, '1));
		send_beat(make_cmd(MODE_GO, 1'b0, '1, '0, '0));
		send_beat(make_cmd(MODE_ROOT, 1'b0, '0, '0, '0));
	endtask

	// walks down the tree toward chosen targets, probing along the way
	task automatic test_descent(input int n_items);
		int     goal, walk_len, op;
		bit     s;
		field_t tn, td, kk;
		steps_t lim;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0)
				send_beat(make_cmd(MODE_ROOT, 1'($urandom), $urandom, $urandom, $urandom));
			pick_target(tn, td);
			walk_len = $urandom_range(4, 16);
			repeat (walk_len) begin
				op = $urandom_range(0, 99);
				s  = 1'($urandom_range(0, 1));
				if (op < 50) begin
					lim = approach_limit(s, wide_t'(tn), wide_t'(td));
					send_beat(make_cmd(MODE_APPROACH, s, $urandom, tn, td));
					if (lim > 0) begin
						kk = field_t'(lim);
						if ($urandom_range(0, 4) == 0)
							kk = kk + 1;
						send_beat(make_cmd(MODE_GO, s, kk, $urandom, $urandom));
					end
				end else if (op < 70) begin
					send_beat(make_cmd(MODE_CONTAINS, s, $urandom, tn, td));
				end else if (op < 85) begin
					kk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000)
					                                 : $urandom_range(0, 6);
					send_beat(make_cmd(MODE_GO, s, kk, $urandom, $urandom));
				end else begin
					pick_target(tn, td);
					send_beat(make_cmd(MODE_APPROACH, s, $urandom, tn, td));
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	// unstructured commands with random bits in every field
	task automatic test_noise(input int n_items);
		field_t k, tn, td;
		repeat (n_items) begin
			k  = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 9);
			tn = ($urandom_range(0, 2) != 0) ? $urandom : $urandom_range(0, 3);
			td = ($urandom_range(0, 2) != 0) ? $urandom : $urandom_range(0, 3);
			send_beat(make_cmd(2'($urandom_range(0, 3)), 1'($urandom), k, tn, td));
		end
	endtask

	function automatic void check_field(string field, logic signed [63:0] want,
	                                    logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// compare each result beat with the oldest pending prediction
	always @(posedge clk) begin : result_check
		sbn_out_t want;
		if (arst_n && done) begin
			if (node_expect_q.size() == 0) begin
				$display("%0t ns: result with no command pending, got %p", $time, res);
				fail_count++;
			end else begin
				want = node_expect_q.pop_front();
				check_field("max_steps", 64'(want.max_steps), 64'(res.max_steps));
				check_field("inside_res", 64'(want.inside_res), 64'(res.inside_res));
				check_field("mediant_num", 64'(want.mediant_num), 64'(res.mediant_num));
				check_field("mediant_den", 64'(want.mediant_den), 64'(res.mediant_den));
				check_field("overflow", 64'(want.overflow), 64'(res.overflow));
			end
		end
	end

	// ends a run where neither side moves any more
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall = 0;
			else
				stall++;
		end
		$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		lb_num = 0;
		lb_den = 1;
		rb_num = 1;
		rb_den = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_descent(520);
		test_noise(110);

		// drain
		@(negedge clk);
		start <= 1'b0;
		while (node_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
